[src/netstring_deframer_core_assert.svh]
// Assertion helpers shared by the deframer RTL.
`ifndef NETSTRING_DEFRAMER_CORE_ASSERT_SVH
`define NETSTRING_DEFRAMER_CORE_ASSERT_SVH

// pre implies post in the same cycle, checked out of reset.
`define NSD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// pre implies post in the following cycle, checked out of reset.
`define NSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/nsd_pkg.sv]
package nsd_pkg;

  // Widths of the stream and of the decoded length.
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 30;

  // Longest accepted decimal length field.
  localparam int unsigned MaxDigits = 9;
  localparam int unsigned DigW      = $clog2(MaxDigits + 1);

  // Configuration port.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegLimitEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxLength   = 1'd1;
  localparam logic [LenW-1:0]    MaxLenReset    = 30'd999999999;
  localparam logic [LenW-1:0]    LenSat         = '1;

  // Framing characters.
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_DISCARD  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TOO_LONG   = 3'd1,
    ERR_LEAD_ZERO  = 3'd2,
    ERR_NO_LENGTH  = 3'd3,
    ERR_NO_COLON   = 3'd4,
    ERR_OVER_LIMIT = 3'd5,
    ERR_NO_COMMA   = 3'd6
  } err_e;

  typedef struct packed {
    logic            limit_en;
    logic [LenW-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] payload_byte;
    logic             payload_last;
    logic [LenW-1:0]  frame_length;
    logic             header_done;
    err_e             error_code;
  } res_t;

endpackage

[src/netstring_deframer_core.sv]
// Channel   Direction  Handshake              Beat contents
// input     in         in_valid_i/in_stall_o  data_byte_i
// output    out        out_valid_o/out_stall_i byte_kind_o, payload_byte_o, payload_last_o,
//                                             frame_length_o, header_done_o, error_code_o
// config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One byte is taken per cycle while in_stall_o is low; its result is held in
// the output register or the skid stage. The path from data_byte_i through the
// deframer state update (one x10 add and one length compare) into the result
// register sets the cycle. Reset clears the deframer to the header phase and
// the registers to limit off, maximum 999999999. A stalled output fills a
// one-beat skid stage; only when that is also full does in_stall_o rise.

`include "netstring_deframer_core_assert.svh"

module netstring_deframer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [nsd_pkg::ByteW-1:0]   data_byte_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  byte_kind_o,
  output logic [nsd_pkg::ByteW-1:0]   payload_byte_o,
  output logic                        payload_last_o,
  output logic [nsd_pkg::LenW-1:0]    frame_length_o,
  output logic                        header_done_o,
  output logic [2:0]                  error_code_o,

  input  logic                        cfg_we_i,
  input  logic [nsd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nsd_pkg::LenW-1:0]    cfg_wdata_i
);

  nsd_pkg::cfg_t cfg_q;
  nsd_pkg::res_t res;
  nsd_pkg::res_t out_q, skid_q;
  logic          out_valid_q, skid_valid_q;
  logic          in_acc, out_take;

  // Configuration registers, no read-back: the user writes them only while idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_en <= 1'b0;
      cfg_q.max_len  <= nsd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nsd_pkg::RegLimitEnable: cfg_q.limit_en <= cfg_wdata_i[0];
        nsd_pkg::RegMaxLength:   cfg_q.max_len  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the skid stage is free.
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  nsd_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .data_i   (data_byte_i),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  // Output control: the output register shows the oldest beat, the skid
  // stage holds one more while the consumer stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: advance from skid, load fresh, or hold.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_kind_o    = out_q.kind;
  assign payload_byte_o = out_q.payload_byte;
  assign payload_last_o = out_q.payload_last;
  assign frame_length_o = out_q.frame_length;
  assign header_done_o  = out_q.header_done;
  assign error_code_o   = out_q.error_code;

  `NSD_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
                  "skid stage full while output register empty")
  `NSD_ASSERT_IMP(a_header_done_kind, clk_i, rst_ni, out_valid_q && out_q.header_done,
                  out_q.kind == nsd_pkg::KIND_HEADER && out_q.error_code == nsd_pkg::ERR_NONE,
                  "header done on a non-header beat")
  `NSD_ASSERT_IMP(a_discard_has_code, clk_i, rst_ni,
                  out_valid_q && out_q.kind == nsd_pkg::KIND_DISCARD,
                  out_q.error_code != nsd_pkg::ERR_NONE, "discard beat without error code")

endmodule

[src/nsd_step.sv]
`include "netstring_deframer_core_assert.svh"

module nsd_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [nsd_pkg::ByteW-1:0] data_i,
  input  nsd_pkg::cfg_t            cfg_i,
  output nsd_pkg::res_t            res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  localparam int unsigned MulW = nsd_pkg::LenW + 4;

  phase_e                     phase_q, phase_d;
  logic [nsd_pkg::LenW-1:0]   acc_q, acc_d;
  logic [nsd_pkg::DigW-1:0]   cnt_q, cnt_d;
  logic                       lz_q, lz_d;
  logic [nsd_pkg::LenW-1:0]   rem_q, rem_d;
  nsd_pkg::err_e              err_q, err_d;

  logic                       is_digit;
  logic [3:0]                 digit;
  logic [MulW-1:0]            mul10;
  logic [nsd_pkg::LenW-1:0]   acc_sat;
  nsd_pkg::res_t              res;

  assign is_digit = (data_i >= nsd_pkg::ChZero) && (data_i <= nsd_pkg::ChNine);
  assign digit    = 4'(data_i - nsd_pkg::ChZero);
  // acc * 10 + d as (acc << 3) + (acc << 1) + d
  assign mul10    = MulW'({acc_q, 3'b000}) + MulW'({acc_q, 1'b0}) + MulW'(digit);
  assign acc_sat  = (mul10[MulW-1:nsd_pkg::LenW] != '0) ? nsd_pkg::LenSat
                                                       : mul10[nsd_pkg::LenW-1:0];

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    lz_d    = lz_q;
    rem_d   = rem_q;
    err_d   = err_q;

    res              = '0;
    res.kind         = nsd_pkg::KIND_HEADER;
    res.error_code   = nsd_pkg::ERR_NONE;

    case (phase_q)
      PH_HEADER: begin
        if (is_digit) begin
          if (cnt_q >= nsd_pkg::DigW'(nsd_pkg::MaxDigits)) begin
            err_d = nsd_pkg::ERR_TOO_LONG;
          end else if (lz_q) begin
            err_d = nsd_pkg::ERR_LEAD_ZERO;
          end else begin
            acc_d = acc_sat;
            lz_d  = (cnt_q == '0) && (digit == 4'd0);
            cnt_d = cnt_q + nsd_pkg::DigW'(1);
          end
        end else if (data_i == nsd_pkg::ChColon) begin
          if (cnt_q == '0) begin
            err_d = nsd_pkg::ERR_NO_LENGTH;
          end else if (cfg_i.limit_en && (acc_q > cfg_i.max_len)) begin
            err_d = nsd_pkg::ERR_OVER_LIMIT;
          end else begin
            res.frame_length = acc_q;
            res.header_done  = 1'b1;
            if (acc_q == '0) begin
              phase_d = PH_TRAILER;
            end else begin
              rem_d   = acc_q;
              phase_d = PH_PAYLOAD;
            end
          end
        end else begin
          err_d = nsd_pkg::ERR_NO_COLON;
        end
      end
      PH_PAYLOAD: begin
        res.kind         = nsd_pkg::KIND_PAYLOAD;
        res.payload_byte = data_i;
        if (rem_q <= nsd_pkg::LenW'(1)) begin
          rem_d            = '0;
          res.payload_last = 1'b1;
          phase_d          = PH_TRAILER;
        end else begin
          rem_d = rem_q - nsd_pkg::LenW'(1);
        end
      end
      PH_TRAILER: begin
        if (data_i == nsd_pkg::ChComma) begin
          res.kind         = nsd_pkg::KIND_COMPLETE;
          res.frame_length = acc_q;
          acc_d            = '0;
          cnt_d            = '0;
          lz_d             = 1'b0;
          rem_d            = '0;
          phase_d          = PH_HEADER;
        end else begin
          err_d = nsd_pkg::ERR_NO_COMMA;
        end
      end
      default: begin
        res.kind       = nsd_pkg::KIND_DISCARD;
        res.error_code = err_q;
      end
    endcase

    // a fresh error: report it now and park in the error phase
    if (phase_q != PH_ERROR && err_d != nsd_pkg::ERR_NONE) begin
      res            = '0;
      res.kind       = nsd_pkg::KIND_ERROR;
      res.error_code = err_d;
      phase_d        = PH_ERROR;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      acc_q   <= '0;
      cnt_q   <= '0;
      lz_q    <= 1'b0;
      rem_q   <= '0;
      err_q   <= nsd_pkg::ERR_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      lz_q    <= lz_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

  `NSD_ASSERT_NEXT(a_error_sticks, clk_i, rst_ni, phase_q == PH_ERROR,
                   phase_q == PH_ERROR && $stable(err_q), "error phase was left")
  `NSD_ASSERT_IMP(a_payload_count, clk_i, rst_ni, phase_q == PH_PAYLOAD,
                  rem_q != '0, "payload phase with no bytes left")
  `NSD_ASSERT_IMP(a_error_code_set, clk_i, rst_ni, phase_q == PH_ERROR,
                  err_q != nsd_pkg::ERR_NONE, "error phase without a code")

endmodule

[verif/tb_netstring_deframer_core.sv]
`timescale 1ns / 100ps

module tb_netstring_deframer_core;
  import nsd_pkg::*;

  // Cycles without any accepted beat or register write before the run is
  // declared hung. The long receiver hold-off is well below this.
  localparam int unsigned StallLimit = 1000;
  // Receiver hold-off: starts once this many bytes went in, lasts HoldCycles.
  localparam int unsigned HoldAt     = 520;
  localparam int unsigned HoldCycles = 80;
  // Window of input beats in which neither side idles.
  localparam int unsigned QuietLo    = 300;
  localparam int unsigned QuietHi    = 420;
  localparam int unsigned PhaseBytes = 110;

  // Phase of the predicted deframer.
  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PAYLOAD,
    ST_TRAILER,
    ST_FAILED
  } rx_phase_e;

  typedef struct {
    logic [ByteW-1:0] data;
    bit               typed;
    res_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   data_byte = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         byte_kind;
  logic [ByteW-1:0]   payload_byte;
  logic               payload_last;
  logic [LenW-1:0]    frame_length;
  logic               header_done;
  logic [2:0]         error_code;

  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [LenW-1:0]    cfg_wdata = '0;

  // Predictor copy of the configuration and of the deframer state.
  logic               lim_en  = 1'b0;
  logic [LenW-1:0]    lim_max = MaxLenReset;
  rx_phase_e          fr_phase = ST_HEADER;
  logic [LenW-1:0]    len_acc  = '0;
  logic [DigW-1:0]    n_digits = '0;
  logic               zero_lead = 1'b0;
  logic [LenW-1:0]    remaining = '0;
  err_e               held_err = ERR_NONE;

  res_t        deframed_q[$];
  dir_row_t    dir_rows[$];
  int unsigned n_sent = 0;
  int unsigned n_fail = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always #2 clk = ~clk;

  netstring_deframer_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_kind_o    (byte_kind),
    .payload_byte_o (payload_byte),
    .payload_last_o (payload_last),
    .frame_length_o (frame_length),
    .header_done_o  (header_done),
    .error_code_o   (error_code),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Advance the predicted deframer by one byte and return its result beat.
  function automatic res_t deframe_byte(logic [ByteW-1:0] b);
    res_t       r;
    err_e       code;
    logic [35:0] wide;
    r    = '0;
    code = ERR_NONE;
    r.kind = KIND_HEADER;
    r.error_code = ERR_NONE;
    case (fr_phase)
      ST_FAILED: begin
        r.kind = KIND_DISCARD;
        r.error_code = held_err;
      end
      ST_HEADER: begin
        if (b >= ChZero && b <= ChNine) begin
          // Digit count is checked ahead of the leading zero.
          if (n_digits >= MaxDigits) begin
            code = ERR_TOO_LONG;
          end else if (zero_lead) begin
            code = ERR_LEAD_ZERO;
          end else begin
            wide = 36'(len_acc) * 36'd10 + 36'(b - ChZero);
            len_acc = (wide > 36'(LenSat)) ? LenSat : wide[LenW-1:0];
            if (n_digits == 0 && b == ChZero) zero_lead = 1'b1;
            n_digits = n_digits + DigW'(1);
          end
        end else if (b == ChColon) begin
          if (n_digits == 0) begin
            code = ERR_NO_LENGTH;
          end else if (lim_en && len_acc > lim_max) begin
            code = ERR_OVER_LIMIT;
          end else begin
            r.frame_length = len_acc;
            r.header_done = 1'b1;
            if (len_acc == 0) begin
              fr_phase = ST_TRAILER;
            end else begin
              remaining = len_acc;
              fr_phase = ST_PAYLOAD;
            end
          end
        end else begin
          code = ERR_NO_COLON;
        end
      end
      ST_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        if (remaining <= 1) begin
          remaining = '0;
          r.payload_last = 1'b1;
          fr_phase = ST_TRAILER;
        end else begin
          remaining = remaining - LenW'(1);
        end
      end
      default: begin
        if (b != ChComma) begin
          code = ERR_NO_COMMA;
        end else begin
          r.kind = KIND_COMPLETE;
          r.frame_length = len_acc;
          len_acc = '0;
          n_digits = '0;
          zero_lead = 1'b0;
          remaining = '0;
          fr_phase = ST_HEADER;
        end
      end
    endcase
    // Any violation locks the deframer until reset.
    if (code != ERR_NONE) begin
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      held_err = code;
      fr_phase = ST_FAILED;
    end
    return r;
  endfunction

  function automatic void add_typed(logic [ByteW-1:0] b, kind_e k, logic [ByteW-1:0] pb,
                                    logic last, logic [LenW-1:0] len, logic hd);
    dir_row_t row;
    row.data = b;
    row.typed = 1'b1;
    row.want = '0;
    row.want.kind = k;
    row.want.payload_byte = pb;
    row.want.payload_last = last;
    row.want.frame_length = len;
    row.want.header_done = hd;
    row.want.error_code = ERR_NONE;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [ByteW-1:0] b);
    dir_row_t row;
    row.data = b;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic bit sender_idles();
    if (n_sent >= QuietLo && n_sent < QuietHi) return 1'b0;
    return $urandom_range(0, 99) < 12;
  endfunction

  // Payload content: mostly random, sometimes a framing character.
  function automatic logic [ByteW-1:0] pick_payload();
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return ChColon;
      1:       return ChComma;
      2:       return ChZero;
      default: return ChNine;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_fail++;
    end
  endfunction

  // Offer one beat and hold it until accepted. Valid stays high on return so
  // that a following beat goes out back to back.
  task automatic send_byte(logic [ByteW-1:0] b, bit typed = 1'b0, res_t want = '0);
    res_t got;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    got = deframe_byte(b);
    deframed_q.push_back(typed ? want : got);
    n_sent++;
  endtask

  // Drop valid and wait until every predicted beat came out.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == RegLimitEnable) lim_en = val[0];
    else lim_max = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_length(int unsigned n);
    logic [ByteW-1:0] dig[$];
    do begin
      dig.push_front(ChZero + 8'(n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (dig[i]) send_byte(dig[i]);
  endtask

  task automatic send_frame(int unsigned len);
    send_length(len);
    send_byte(ChColon);
    repeat (len) send_byte(pick_payload());
    send_byte(ChComma);
  endtask

  task automatic run_phase(logic en, logic [LenW-1:0] mx, int unsigned items);
    int unsigned start;
    int unsigned len;
    settle_idle();
    write_reg(RegLimitEnable, LenW'(en));
    write_reg(RegMaxLength, mx);
    start = n_sent;
    while (n_sent - start < items) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 260) : $urandom_range(0, 24);
      if (lim_en) begin
        // Hit the limit exactly now and then; otherwise stay at or below it.
        if (lim_max <= 300 && $urandom_range(0, 3) == 0) len = lim_max;
        else len = len % (32'(lim_max) + 1);
      end
      send_frame(len);
    end
  endtask

  // Break the stream in one of the ways the header and trailer checks catch.
  task automatic inject_error();
    err_e             pick;
    int unsigned      mx;
    int unsigned      k;
    logic [ByteW-1:0] b;
    pick = err_e'($urandom_range(int'(ERR_NO_COMMA), int'(ERR_TOO_LONG)));
    case (pick)
      ERR_TOO_LONG: begin
        send_byte(ChZero + 8'($urandom_range(1, 9)));
        repeat (MaxDigits) send_byte(ChZero + 8'($urandom_range(0, 9)));
      end
      ERR_LEAD_ZERO: begin
        send_byte(ChZero);
        send_byte(ChZero + 8'($urandom_range(0, 9)));
      end
      ERR_NO_LENGTH: begin
        send_byte(ChColon);
      end
      ERR_NO_COLON: begin
        k = $urandom_range(0, 3);
        if (k != 0) send_byte(ChZero + 8'($urandom_range(1, 9)));
        repeat ((k > 1) ? k - 1 : 0) send_byte(ChZero + 8'($urandom_range(0, 9)));
        do b = 8'($urandom_range(0, 255));
        while ((b >= ChZero && b <= ChNine) || b == ChColon);
        send_byte(b);
      end
      ERR_OVER_LIMIT: begin
        settle_idle();
        write_reg(RegLimitEnable, LenW'(1));
        if ($urandom_range(0, 1) == 0) begin
          // Longest legal length, one above the limit.
          write_reg(RegMaxLength, MaxLenReset - 1'b1);
          send_length(MaxLenReset);
        end else begin
          mx = $urandom_range(0, 50);
          write_reg(RegMaxLength, LenW'(mx));
          send_length(mx + 1 + $urandom_range(0, 20));
        end
        send_byte(ChColon);
      end
      default: begin
        k = $urandom_range(0, 5);
        send_length(k);
        send_byte(ChColon);
        repeat (k) send_byte(pick_payload());
        do b = pick_payload(); while (b == ChComma);
        send_byte(b);
      end
    endcase
  endtask

  // Receiver: random stall, a quiet window, and one long hold-off that lets
  // the skid stage fill so the input stalls while bytes are still offered.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_sent >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (n_sent >= QuietLo && n_sent < QuietHi) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 12);
    end
  end

  // Compare every output beat with the oldest predicted one.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: output beat with nothing expected, expected none, got kind %0h",
                 $time, byte_kind);
        n_fail++;
      end else begin
        want = deframed_q.pop_front();
        check_field("byte_kind", 32'(want.kind), 32'(byte_kind));
        check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
        check_field("payload_last", 32'(want.payload_last), 32'(payload_last));
        check_field("frame_length", 32'(want.frame_length), 32'(frame_length));
        check_field("header_done", 32'(want.header_done), 32'(header_done));
        check_field("error_code", 32'(want.error_code), 32'(error_code));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[netstring_deframer_core] ERROR");
    $finish;
  end

  initial begin
    // Directed frames under reset configuration: empty frame, two extreme
    // payload bytes, then a two-digit length over framing characters.
    add_typed(ChZero, KIND_HEADER, '0, 1'b0, '0, 1'b0);
    add_typed(ChColon, KIND_HEADER, '0, 1'b0, '0, 1'b1);
    add_typed(ChComma, KIND_COMPLETE, '0, 1'b0, '0, 1'b0);
    add_typed(ChZero + 8'd2, KIND_HEADER, '0, 1'b0, '0, 1'b0);
    add_typed(ChColon, KIND_HEADER, '0, 1'b0, LenW'(2), 1'b1);
    add_typed(8'h00, KIND_PAYLOAD, 8'h00, 1'b0, '0, 1'b0);
    add_typed(8'hFF, KIND_PAYLOAD, 8'hFF, 1'b1, '0, 1'b0);
    add_typed(ChComma, KIND_COMPLETE, '0, 1'b0, LenW'(2), 1'b0);
    add_checked(ChZero + 8'd1);
    add_checked(ChZero);
    add_checked(ChColon);
    add_checked(ChColon);
    add_checked(ChComma);
    add_checked(ChZero);
    add_checked(ChNine);
    add_checked(8'h80);
    add_checked(8'h7F);
    add_checked(8'h55);
    add_checked(8'hAA);
    add_checked(8'h01);
    add_checked(8'hFE);
    add_checked(ChComma);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

    // Random frames over several limit settings, extremes included.
    run_phase(1'b1, '0, PhaseBytes);
    run_phase(1'b1, LenW'($urandom_range(1, 40)), PhaseBytes);
    run_phase(1'b0, '0, PhaseBytes);
    run_phase(1'b1, LenSat, PhaseBytes);
    run_phase(1'b1, MaxLenReset, PhaseBytes);

    // The error is sticky, so it comes last; then feed discarded noise.
    inject_error();
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (n_fail == 0) begin
      $display("[netstring_deframer_core] OK");
    end else begin
      $display("[netstring_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
